### sv/rgbb_pkg.sv
// rgbb_pkg: widths, constants and the pipeline beat types for the gaussian box block
// used by rgbb_axis and rotated_gaussian_bounding_box_top
package rgbb_pkg;

  localparam int unsigned QuatW   = 16;
  localparam int unsigned MeanW   = 32;
  localparam int unsigned SigmaW  = 24;
  localparam int unsigned ConfW   = 24;
  localparam int unsigned RotW    = 33;  // signed Q28 rotation entry
  localparam int unsigned RmagW   = 22;  // |R| at Q16
  localparam int unsigned T16W    = 30;  // t rounded to Q16
  localparam int unsigned SumW    = 61;  // sum of three squares
  localparam int unsigned ProdW   = 64;  // clamped P
  localparam int unsigned RootW   = 33;  // extent, up to 2^32
  localparam int unsigned SqrtSteps = 32;

  localparam logic [ConfW-1:0] ConfReset = 24'd512146;

  // magnitude of a Q28 entry rounded half away from zero to Q16
  function automatic logic [RmagW-1:0] round_mag(input logic signed [RotW-1:0] v);
    logic [RotW-1:0] a;
    logic [RotW:0]   s;
    begin
      a = v[RotW-1] ? RotW'(-v) : RotW'(v);
      s = {1'b0, a} + (RotW+1)'(2048);
      round_mag = RmagW'(s >> 12);
    end
  endfunction

  // one restoring square-root step: remainder, partial root, two radicand bits
  typedef struct packed {
    logic [RootW+1:0] rem;
    logic [RootW-1:0] root;
    logic [ProdW-1:0] rad;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    sqrt_st_t o;
    logic [RootW+1:0] r2;
    logic [RootW+1:0] trial;
    begin
      r2    = {s.rem[RootW-1:0], s.rad[ProdW-1:ProdW-2]};
      trial = {s.root, 2'b01};
      o.rad = {s.rad[ProdW-3:0], 2'b00};
      if (r2 >= trial) begin
        o.rem  = r2 - trial;
        o.root = {s.root[RootW-2:0], 1'b1};
      end else begin
        o.rem  = r2;
        o.root = {s.root[RootW-2:0], 1'b0};
      end
      sqrt_step = o;
    end
  endfunction

endpackage

### sv/rgbb_axis.sv
// rgbb_axis: pipelined half extent and box bounds for one world axis
// depends on rgbb_pkg; takes one row of the rotation matrix per beat
module rgbb_axis (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [rgbb_pkg::RotW-1:0]     r0,
  input  logic signed [rgbb_pkg::RotW-1:0]     r1,
  input  logic signed [rgbb_pkg::RotW-1:0]     r2,
  input  logic        [rgbb_pkg::SigmaW-1:0]   s0,
  input  logic        [rgbb_pkg::SigmaW-1:0]   s1,
  input  logic        [rgbb_pkg::SigmaW-1:0]   s2,
  input  logic        [rgbb_pkg::ConfW-1:0]    conf,
  input  logic signed [rgbb_pkg::MeanW-1:0]    mean,
  output logic                                 out_valid,
  output logic signed [rgbb_pkg::MeanW-1:0]    lo,
  output logic signed [rgbb_pkg::MeanW-1:0]    hi
);

  localparam int unsigned Lat = 6 + rgbb_pkg::SqrtSteps / 2;

  // valid shift line; mean and conf delayed alongside
  logic [Lat-1:0] vld;
  logic signed [rgbb_pkg::MeanW-1:0] mean_d [Lat];
  logic [rgbb_pkg::ConfW-1:0] conf_d [4];

  // stage 1: magnitudes
  logic [rgbb_pkg::RmagW-1:0]  m0, m1, m2;
  logic [rgbb_pkg::SigmaW-1:0] g0, g1, g2;
  // stage 2: t rounded
  logic [rgbb_pkg::T16W-1:0] t0, t1, t2;
  // stage 3: squares
  logic [59:0] q0, q1, q2;
  // stage 4: sum split
  logic [rgbb_pkg::SumW-1:0] sum;
  // stage 5: products
  logic [68:0] phi;
  logic [40:0] plo;
  // stage 6: clamped P
  logic [rgbb_pkg::ProdW-1:0] p;
  // sqrt stages, two steps each
  rgbb_pkg::sqrt_st_t sq [rgbb_pkg::SqrtSteps/2];

  logic [rgbb_pkg::RmagW+rgbb_pkg::SigmaW-1:0] tp0, tp1, tp2;
  logic [68:0] psum;
  assign tp0 = 46'(m0) * 46'(g0);
  assign tp1 = 46'(m1) * 46'(g1);
  assign tp2 = 46'(m2) * 46'(g2);
  assign psum = phi + 69'(plo >> 16);

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Lat-2:0], in_valid};
    mean_d[0] <= mean;
    for (int i = 1; i < Lat; i++) mean_d[i] <= mean_d[i-1];
    conf_d[0] <= conf;
    for (int i = 1; i < 4; i++) conf_d[i] <= conf_d[i-1];
    m0 <= rgbb_pkg::round_mag(r0);
    m1 <= rgbb_pkg::round_mag(r1);
    m2 <= rgbb_pkg::round_mag(r2);
    g0 <= s0; g1 <= s1; g2 <= s2;
    t0 <= rgbb_pkg::T16W'((tp0 + 46'd32768) >> 16);
    t1 <= rgbb_pkg::T16W'((tp1 + 46'd32768) >> 16);
    t2 <= rgbb_pkg::T16W'((tp2 + 46'd32768) >> 16);
    q0 <= 60'(t0) * 60'(t0);
    q1 <= 60'(t1) * 60'(t1);
    q2 <= 60'(t2) * 60'(t2);
    sum <= 61'(q0) + 61'(q1) + 61'(q2);
    phi <= 69'(sum[60:16]) * 69'(conf_d[3]);
    plo <= 41'(sum[15:0]) * 41'(conf_d[3]) + 41'd32768;
    p <= (psum[68:64] != '0) ? '1 : psum[63:0];
  end

  // square root chain, then ceiling and bounds
  always_ff @(posedge clk) begin
    sq[0] <= rgbb_pkg::sqrt_step(rgbb_pkg::sqrt_step('{rem: '0, root: '0, rad: p}));
    for (int i = 1; i < rgbb_pkg::SqrtSteps/2; i++) begin
      sq[i] <= rgbb_pkg::sqrt_step(rgbb_pkg::sqrt_step(sq[i-1]));
    end
  end

  logic [rgbb_pkg::RootW-1:0] e;
  logic signed [rgbb_pkg::MeanW+1:0] dl, dh;
  assign e  = sq[rgbb_pkg::SqrtSteps/2-1].root +
              rgbb_pkg::RootW'(sq[rgbb_pkg::SqrtSteps/2-1].rem != '0);
  assign dl = 34'(mean_d[Lat-1]) - 34'(signed'({1'b0, e}));
  assign dh = 34'(mean_d[Lat-1]) + 34'(signed'({1'b0, e}));

  // output register with saturation
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[Lat-1];
    lo <= (dl < -34'sd2147483648) ? 32'sh80000000 : dl[31:0];
    hi <= (dh > 34'sd2147483647) ? 32'sh7fffffff : dh[31:0];
  end

endmodule

### sv/rotated_gaussian_bounding_box_top.sv
// rotated_gaussian_bounding_box_top: box of the confidence ellipsoid of one gaussian
// depends on rgbb_pkg and rgbb_axis (one instance per world axis)
//
//  channel   signals                                 beat
//  cmd       start, busy, quat_*, mean_*, sigma_*     start && !busy
//  cfg       cfg_valid, cfg_ready, cfg_data           cfg_valid && cfg_ready
//  result    done, box_min_*, box_max_*               done (one cycle)
//
// one gaussian per cycle. The rotation matrix is registered, then come
// scaling, sum and confidence product, the square root (two bits a
// stage) and the bounds register. busy is always low, the
// receiver cannot stall, so nothing is ever held. rst is synchronous and
// clears valid bits and confidence_scale to its default.
module rotated_gaussian_bounding_box_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rgbb_pkg::QuatW-1:0]  quat_x,
  input  logic signed [rgbb_pkg::QuatW-1:0]  quat_y,
  input  logic signed [rgbb_pkg::QuatW-1:0]  quat_z,
  input  logic signed [rgbb_pkg::QuatW-1:0]  quat_w,
  input  logic signed [rgbb_pkg::MeanW-1:0]  mean_x,
  input  logic signed [rgbb_pkg::MeanW-1:0]  mean_y,
  input  logic signed [rgbb_pkg::MeanW-1:0]  mean_z,
  input  logic        [rgbb_pkg::SigmaW-1:0] sigma_x,
  input  logic        [rgbb_pkg::SigmaW-1:0] sigma_y,
  input  logic        [rgbb_pkg::SigmaW-1:0] sigma_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [rgbb_pkg::ConfW-1:0]  cfg_data,
  output logic                               done,
  output logic signed [rgbb_pkg::MeanW-1:0]  box_min_x,
  output logic signed [rgbb_pkg::MeanW-1:0]  box_max_x,
  output logic signed [rgbb_pkg::MeanW-1:0]  box_min_y,
  output logic signed [rgbb_pkg::MeanW-1:0]  box_max_y,
  output logic signed [rgbb_pkg::MeanW-1:0]  box_min_z,
  output logic signed [rgbb_pkg::MeanW-1:0]  box_max_z
);

  localparam int unsigned RW = rgbb_pkg::RotW;

  logic [rgbb_pkg::ConfW-1:0] confidence_scale;
  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // confidence register
  always_ff @(posedge clk) begin
    if (rst) confidence_scale <= rgbb_pkg::ConfReset;
    else if (cfg_valid && cfg_ready) confidence_scale <= cfg_data;
  end

  // quaternion products, all Q28
  logic signed [31:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  assign xx = 32'(quat_x) * 32'(quat_x);
  assign yy = 32'(quat_y) * 32'(quat_y);
  assign zz = 32'(quat_z) * 32'(quat_z);
  assign xy = 32'(quat_x) * 32'(quat_y);
  assign xz = 32'(quat_x) * 32'(quat_z);
  assign yz = 32'(quat_y) * 32'(quat_z);
  assign xw = 32'(quat_x) * 32'(quat_w);
  assign yw = 32'(quat_y) * 32'(quat_w);
  assign zw = 32'(quat_z) * 32'(quat_w);

  logic signed [RW-1:0] one;
  assign one = RW'(1) <<< 28;

  // rotation matrix stage
  logic v1;
  logic signed [RW-1:0] m [3][3];
  logic [rgbb_pkg::SigmaW-1:0] sg [3];
  logic signed [rgbb_pkg::MeanW-1:0] mn [3];
  logic [rgbb_pkg::ConfW-1:0] cf;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start && !busy;
    m[0][0] <= RW'(one - 2 * (RW'(yy) + RW'(zz)));
    m[0][1] <= RW'(2 * (RW'(xy) - RW'(zw)));
    m[0][2] <= RW'(2 * (RW'(xz) + RW'(yw)));
    m[1][0] <= RW'(2 * (RW'(xy) + RW'(zw)));
    m[1][1] <= RW'(one - 2 * (RW'(xx) + RW'(zz)));
    m[1][2] <= RW'(2 * (RW'(yz) - RW'(xw)));
    m[2][0] <= RW'(2 * (RW'(xz) - RW'(yw)));
    m[2][1] <= RW'(2 * (RW'(yz) + RW'(xw)));
    m[2][2] <= RW'(one - 2 * (RW'(xx) + RW'(yy)));
    sg[0] <= sigma_x; sg[1] <= sigma_y; sg[2] <= sigma_z;
    mn[0] <= mean_x;  mn[1] <= mean_y;  mn[2] <= mean_z;
    cf <= confidence_scale;
  end

  logic [2:0] dv;
  rgbb_axis u_ax (.clk, .rst, .in_valid(v1), .r0(m[0][0]), .r1(m[0][1]), .r2(m[0][2]),
    .s0(sg[0]), .s1(sg[1]), .s2(sg[2]), .conf(cf), .mean(mn[0]),
    .out_valid(dv[0]), .lo(box_min_x), .hi(box_max_x));
  rgbb_axis u_ay (.clk, .rst, .in_valid(v1), .r0(m[1][0]), .r1(m[1][1]), .r2(m[1][2]),
    .s0(sg[0]), .s1(sg[1]), .s2(sg[2]), .conf(cf), .mean(mn[1]),
    .out_valid(dv[1]), .lo(box_min_y), .hi(box_max_y));
  rgbb_axis u_az (.clk, .rst, .in_valid(v1), .r0(m[2][0]), .r1(m[2][1]), .r2(m[2][2]),
    .s0(sg[0]), .s1(sg[1]), .s2(sg[2]), .conf(cf), .mean(mn[2]),
    .out_valid(dv[2]), .lo(box_min_z), .hi(box_max_z));

  assign done = dv[0];

  // checks
  a_lanes: assert property (@(posedge clk) disable iff (rst) dv[0] == dv[1] && dv[1] == dv[2])
    else $error("axis lanes out of step");
  a_order: assert property (@(posedge clk) disable iff (rst) done |-> box_min_x <= box_max_x)
    else $error("x bounds inverted");
  a_ordz: assert property (@(posedge clk) disable iff (rst) done |-> box_min_z <= box_max_z)
    else $error("z bounds inverted");

endmodule
